@@ sv/diffie_hellman_modexp_defines.svh @@
// ----------------------------------------------------------------------------
// diffie_hellman_modexp assertion macros
// shared property forms for the port checker; clk and arst_n come from the
// scope that uses them
// ----------------------------------------------------------------------------
`ifndef DIFFIE_HELLMAN_MODEXP_DEFINES_SVH
`define DIFFIE_HELLMAN_MODEXP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define DH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error("next-cycle check failed");

// expression must never be true
`define DH_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		!(expr)) else $error("forbidden condition seen");

`endif

@@ sv/dh_pkg.sv @@
// ----------------------------------------------------------------------------
// dh_pkg
// widths, register indexes, state types and unit interface structs shared by
// the modular exponentiation block
// ----------------------------------------------------------------------------
package dh_pkg;

	localparam int MOD_WIDTH     = 32;
	localparam int EXP_WIDTH     = 64;
	localparam int DATA_WIDTH    = 32;
	localparam int CFG_WIDTH     = 64;
	localparam int IDX_WIDTH     = 2;
	localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
	localparam int RED_CNT_WIDTH = $clog2(PROD_WIDTH);

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_MODULUS   = 2'd0,
		REG_GENERATOR = 2'd1,
		REG_EXPONENT  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_PUBLIC = 1'b0,
		OP_SHARED = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_MUL,
		MM_RED
	} mm_state_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_BASE,
		SEQ_STEP,
		SEQ_MUL_ACC,
		SEQ_SHIFT,
		SEQ_SQR,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic                  start;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic                 done;
		logic [MOD_WIDTH-1:0] result;
	} mm_rsp_t;

endpackage

@@ sv/dh_modmul.sv @@
// ----------------------------------------------------------------------------
// dh_modmul
// shared modular multiplier: one registered product, then a restoring
// remainder that takes one product bit per cycle
// ----------------------------------------------------------------------------
module dh_modmul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dh_pkg::mm_req_t                req,
	input  logic [dh_pkg::MOD_WIDTH-1:0]   modulus,
	output dh_pkg::mm_rsp_t                rsp
);

	localparam logic [dh_pkg::RED_CNT_WIDTH-1:0] RED_LAST =
		dh_pkg::RED_CNT_WIDTH'(dh_pkg::PROD_WIDTH - 1);

	dh_pkg::mm_state_t                     state_q;
	dh_pkg::mm_state_t                     state_d;
	logic [dh_pkg::DATA_WIDTH-1:0]         a_q;
	logic [dh_pkg::DATA_WIDTH-1:0]         b_q;
	logic [dh_pkg::PROD_WIDTH-1:0]         prod_q;
	logic [dh_pkg::PROD_WIDTH-1:0]         product;
	logic [dh_pkg::MOD_WIDTH-1:0]          rem_q;
	logic [dh_pkg::RED_CNT_WIDTH-1:0]      cnt_q;
	logic [dh_pkg::MOD_WIDTH:0]            trial;
	logic [dh_pkg::MOD_WIDTH:0]            diff;
	logic                                  fits;
	logic [dh_pkg::MOD_WIDTH-1:0]          rem_next;
	logic                                  last;

	assign product  = a_q * b_q;
	// bring down the next product bit and subtract the modulus if it fits
	assign trial    = {rem_q, prod_q[dh_pkg::PROD_WIDTH-1]};
	assign diff     = trial - {1'b0, modulus};
	assign fits     = trial >= {1'b0, modulus};
	assign rem_next = fits ? diff[dh_pkg::MOD_WIDTH-1:0] : trial[dh_pkg::MOD_WIDTH-1:0];
	assign last     = cnt_q == RED_LAST;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dh_pkg::MM_IDLE: begin
				if (req.start) state_d = dh_pkg::MM_MUL;
			end
			dh_pkg::MM_MUL: begin
				state_d = dh_pkg::MM_RED;
			end
			dh_pkg::MM_RED: begin
				if (last) state_d = dh_pkg::MM_IDLE;
			end
			default: begin
				state_d = dh_pkg::MM_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp.done   = (state_q == dh_pkg::MM_RED) && last;
		rsp.result = rem_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dh_pkg::MM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dh_pkg::MM_RED) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dh_pkg::MM_IDLE: begin
				if (req.start) begin
					a_q <= req.a;
					b_q <= req.b;
				end
			end
			dh_pkg::MM_MUL: begin
				prod_q <= product;
				rem_q  <= '0;
			end
			dh_pkg::MM_RED: begin
				prod_q <= prod_q << 1;
				rem_q  <= rem_next;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/dh_seq.sv @@
// ----------------------------------------------------------------------------
// dh_seq
// square-and-multiply sequencer: walks the exponent from its low bit and
// issues squarings and accumulator products to the shared multiplier
// ----------------------------------------------------------------------------
module dh_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [dh_pkg::DATA_WIDTH-1:0]   peer_value,
	input  logic [dh_pkg::DATA_WIDTH-1:0]   generator,
	input  logic [dh_pkg::MOD_WIDTH-1:0]    modulus,
	input  logic [dh_pkg::EXP_WIDTH-1:0]    exponent,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dh_pkg::DATA_WIDTH-1:0]   key_value,
	output dh_pkg::mm_req_t                 mm_req,
	input  dh_pkg::mm_rsp_t                 mm_rsp
);

	dh_pkg::seq_state_t                 state_q;
	dh_pkg::seq_state_t                 state_d;
	logic [dh_pkg::MOD_WIDTH-1:0]       acc_q;
	logic [dh_pkg::MOD_WIDTH-1:0]       base_q;
	logic [dh_pkg::EXP_WIDTH-1:0]       exp_q;
	logic [dh_pkg::DATA_WIDTH-1:0]      key_q;
	logic                               exp_zero;
	logic                               mod_small;
	logic                               trivial;
	logic [dh_pkg::DATA_WIDTH-1:0]      base_in;
	logic [dh_pkg::EXP_WIDTH-1:0]       exp_next;
	logic                               more;

	assign exp_zero  = exponent == '0;
	// modulus of zero or one: nothing to reduce, any nonzero power is zero
	assign mod_small = modulus <= dh_pkg::MOD_WIDTH'(1);
	assign trivial   = exp_zero || mod_small;
	assign base_in   = (op == dh_pkg::OP_SHARED) ? peer_value : generator;
	assign exp_next  = exp_q >> 1;
	assign more      = exp_next != '0;
	assign key_value = key_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dh_pkg::SEQ_IDLE: begin
				if (in_valid) state_d = trivial ? dh_pkg::SEQ_DONE : dh_pkg::SEQ_BASE;
			end
			dh_pkg::SEQ_BASE: begin
				if (mm_rsp.done) state_d = dh_pkg::SEQ_STEP;
			end
			dh_pkg::SEQ_STEP: begin
				state_d = exp_q[0] ? dh_pkg::SEQ_MUL_ACC : dh_pkg::SEQ_SHIFT;
			end
			dh_pkg::SEQ_MUL_ACC: begin
				if (mm_rsp.done) state_d = dh_pkg::SEQ_SHIFT;
			end
			dh_pkg::SEQ_SHIFT: begin
				state_d = more ? dh_pkg::SEQ_SQR : dh_pkg::SEQ_DONE;
			end
			dh_pkg::SEQ_SQR: begin
				if (mm_rsp.done) state_d = dh_pkg::SEQ_STEP;
			end
			dh_pkg::SEQ_DONE: begin
				if (out_ready) state_d = dh_pkg::SEQ_IDLE;
			end
			default: begin
				state_d = dh_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = state_q == dh_pkg::SEQ_IDLE;
		out_valid    = state_q == dh_pkg::SEQ_DONE;
		mm_req.start = 1'b0;
		mm_req.a     = dh_pkg::DATA_WIDTH'(base_q);
		mm_req.b     = dh_pkg::DATA_WIDTH'(base_q);
		unique case (state_q)
			dh_pkg::SEQ_IDLE: begin
				// first pass reduces the base below the modulus
				mm_req.start = in_valid && !trivial;
				mm_req.a     = base_in;
				mm_req.b     = dh_pkg::DATA_WIDTH'(1);
			end
			dh_pkg::SEQ_STEP: begin
				mm_req.start = exp_q[0];
				mm_req.a     = dh_pkg::DATA_WIDTH'(acc_q);
			end
			dh_pkg::SEQ_SHIFT: begin
				mm_req.start = more;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dh_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			dh_pkg::SEQ_IDLE: begin
				if (in_valid) begin
					exp_q <= exponent;
					acc_q <= dh_pkg::MOD_WIDTH'(1);
					key_q <= exp_zero ? dh_pkg::DATA_WIDTH'(1) : '0;
				end
			end
			dh_pkg::SEQ_BASE: begin
				if (mm_rsp.done) base_q <= mm_rsp.result;
			end
			dh_pkg::SEQ_MUL_ACC: begin
				if (mm_rsp.done) acc_q <= mm_rsp.result;
			end
			dh_pkg::SEQ_SHIFT: begin
				exp_q <= exp_next;
				if (!more) key_q <= dh_pkg::DATA_WIDTH'(acc_q);
			end
			dh_pkg::SEQ_SQR: begin
				if (mm_rsp.done) base_q <= mm_rsp.result;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/diffie_hellman_modexp.sv @@
// ----------------------------------------------------------------------------
// diffie_hellman_modexp
// modular exponentiation for a key exchange step: public or shared key
// ----------------------------------------------------------------------------
// usage
//   write modulus, generator and private exponent through wr_en, wr_index and
//   wr_data while the block is idle. each transfer on the input channel (op,
//   peer_value) gives one transfer on the output channel (key_value).
//   op 0 raises the generator, op 1 raises peer_value, to the private
//   exponent modulo the modulus.
// operation
//   one shared modular multiplier does all the work: one registered 32x32
//   product and a 64-step restoring remainder for each product.
//   a key costs one base reduction, one squaring per exponent bit above the
//   lowest up to the highest set bit and one product per set exponent bit;
//   a zero exponent or a modulus below 2 skips the multiplier.
//   in_ready is high only while no item is in flight, so one key at a time.
// reset and stalls
//   reset loads modulus 2, generator 2, exponent 0 and empties the block.
//   a finished key is held in the output register with out_valid high until
//   out_ready takes it; the next input transfer is taken after that.
// ----------------------------------------------------------------------------
module diffie_hellman_modexp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [dh_pkg::IDX_WIDTH-1:0]     wr_index,
	input  logic [dh_pkg::CFG_WIDTH-1:0]     wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [dh_pkg::DATA_WIDTH-1:0]    peer_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [dh_pkg::DATA_WIDTH-1:0]    key_value
);

	logic [dh_pkg::MOD_WIDTH-1:0]    modulus_q;
	logic [dh_pkg::DATA_WIDTH-1:0]   generator_q;
	logic [dh_pkg::EXP_WIDTH-1:0]    exponent_q;
	dh_pkg::mm_req_t                 mm_req;
	dh_pkg::mm_rsp_t                 mm_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= dh_pkg::MOD_WIDTH'(2);
			generator_q <= dh_pkg::DATA_WIDTH'(2);
			exponent_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				dh_pkg::REG_MODULUS:   modulus_q   <= wr_data[dh_pkg::MOD_WIDTH-1:0];
				dh_pkg::REG_GENERATOR: generator_q <= wr_data[dh_pkg::DATA_WIDTH-1:0];
				dh_pkg::REG_EXPONENT:  exponent_q  <= wr_data[dh_pkg::EXP_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	dh_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.peer_value (peer_value),
		.generator  (generator_q),
		.modulus    (modulus_q),
		.exponent   (exponent_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_value  (key_value),
		.mm_req     (mm_req),
		.mm_rsp     (mm_rsp)
	);

	dh_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mm_req),
		.modulus (modulus_q),
		.rsp     (mm_rsp)
	);

endmodule

@@ sv/dh_checker.sv @@
// ----------------------------------------------------------------------------
// dh_checker
// port-level checks on the key channel handshakes, bound to the top level
// ----------------------------------------------------------------------------
`include "diffie_hellman_modexp_defines.svh"

module dh_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [dh_pkg::DATA_WIDTH-1:0]    key_value
);

	// a stalled key stays on the port
	`DH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_value))

	// one item at a time: no new input while a key waits
	`DH_ASSERT_NEVER(a_no_overlap, in_ready && out_valid)

	// taking an item closes the input side
	`DH_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

	// delivering the key reopens the input side
	`DH_ASSERT_NEXT(a_ready_after_out, out_valid && out_ready, in_ready && !out_valid)

endmodule

bind diffie_hellman_modexp dh_checker u_dh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.key_value (key_value)
);
